>>> hw/rtl/wss_pkg.sv
package wss_pkg;

  localparam int ADDR_W = 8;
  localparam int DATA_W = 8;
  localparam int WAIT_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int FOLD_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_READ_WAIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_WAIT = 1'd1;

  localparam logic [DATA_W-1:0] ZERO_BYTE = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC
  } state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic calc;
  } cmd_t;

endpackage

>>> hw/rtl/wss_ctrl.sv
module wss_ctrl
  import wss_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   s_tvalid,
  output logic   s_tready,
  output logic   m_tvalid,
  input  logic   m_tready,
  output cmd_t   cmd,
  output state_t ctrl_state
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_CALC;
      end
      ST_CALC: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_CALC: begin
        cmd.calc = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // output register valid; data held in the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.calc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign ctrl_state = state;

endmodule

>>> hw/rtl/wss_dp.sv
module wss_dp
  import wss_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WAIT_W-1:0]    cfg_data,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [DATA_W-1:0]    in_write_byte,
  input  logic                 in_read_enable,
  input  logic                 in_write_enable,
  output logic [DATA_W-1:0]    read_byte,
  output logic                 access_ready
);

  localparam int AW = $clog2(DEPTH);

  // address modulo DEPTH by shifted conditional subtracts
  function automatic logic [FOLD_W-1:0] fold(input logic [ADDR_W-1:0] v);
    logic [FOLD_W-1:0] x;
    x = FOLD_W'(v);
    for (int k = ADDR_W - 1; k >= 0; k--) begin
      if (x >= (FOLD_W'(DEPTH) << k)) x = x - (FOLD_W'(DEPTH) << k);
    end
    return x;
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];

  logic [WAIT_W-1:0] read_wait;
  logic [WAIT_W-1:0] write_wait;

  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wbyte_q;
  logic              ren_q;
  logic              wen_q;

  logic [ADDR_W-1:0] last_address;
  logic              last_read_enable;
  logic              last_write_enable;
  logic [WAIT_W-1:0] read_cnt;
  logic [WAIT_W-1:0] write_cnt;
  logic              read_done;
  logic              write_done;

  logic [DATA_W-1:0] mem_rd;
  logic [AW-1:0]     rd_idx;
  logic [AW-1:0]     wr_idx;

  logic [WAIT_W-1:0] read_cnt_next;
  logic              read_done_next;
  logic [WAIT_W-1:0] write_cnt_next;
  logic              write_done_next;
  logic              commit;
  logic              rdy;
  logic [DATA_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_wait <= '0;
      write_wait <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_READ_WAIT:  read_wait <= cfg_data;
        REG_WRITE_WAIT: write_wait <= cfg_data;
        default:        read_wait <= read_wait;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_q <= in_address;
      wbyte_q <= in_write_byte;
      ren_q <= in_read_enable;
      wen_q <= in_write_enable;
    end
  end

  assign rd_idx = AW'(fold((read_wait == '0) ? addr_q : last_address));
  assign wr_idx = AW'(fold(addr_q));

  always_ff @(posedge clk) begin
    if (cmd.read) mem_rd <= mem[rd_idx];
    if (commit) mem[wr_idx] <= wbyte_q;
  end

  always_comb begin
    rdy = 1'b1;
    if (ren_q) begin
      if (addr_q != last_address) rdy = 1'b0;
      if (read_wait != '0 && (!last_read_enable || !read_done)) rdy = 1'b0;
    end
    if (wen_q) begin
      if (!last_write_enable) rdy = 1'b0;
      if (write_wait != '0 && !write_done) rdy = 1'b0;
    end
    rdata = (read_wait != '0 && !ren_q) ? ZERO_BYTE : mem_rd;
  end

  // read path update
  always_comb begin
    read_cnt_next = read_cnt;
    read_done_next = read_done;
    if (read_wait == '0) begin
      read_cnt_next = '0;
      read_done_next = 1'b1;
    end else if (ren_q) begin
      if (addr_q != last_address || read_cnt == '0) begin
        read_cnt_next = read_wait;
      end else begin
        read_cnt_next = read_cnt - 1'b1;
      end
      read_done_next = (read_cnt_next == '0);
    end else begin
      if (read_cnt == '0) begin
        read_cnt_next = read_wait;
      end else if (read_cnt != read_wait) begin
        read_cnt_next = read_cnt - 1'b1;
      end
      read_done_next = (read_cnt_next == '0) || (read_cnt_next == read_wait);
    end
  end

  // write path update
  always_comb begin
    write_cnt_next = write_cnt;
    write_done_next = write_done;
    commit = 1'b0;
    if (write_wait == '0) begin
      commit = cmd.calc && wen_q;
      write_done_next = 1'b1;
    end else if (wen_q) begin
      if (write_cnt == '0) begin
        write_cnt_next = write_wait;
      end else begin
        write_cnt_next = write_cnt - 1'b1;
      end
      write_done_next = (write_cnt_next == '0);
      commit = cmd.calc && (write_cnt_next == '0);
    end else begin
      if (write_cnt == '0) begin
        write_cnt_next = write_wait;
      end else if (write_cnt != write_wait) begin
        write_cnt_next = write_cnt - 1'b1;
      end
      write_done_next = (write_cnt_next == '0) || (write_cnt_next == write_wait);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_address <= '0;
      last_read_enable <= 1'b0;
      last_write_enable <= 1'b0;
      read_cnt <= '0;
      write_cnt <= '0;
      read_done <= 1'b1;
      write_done <= 1'b1;
    end else if (cmd.calc) begin
      last_address <= addr_q;
      last_read_enable <= ren_q;
      last_write_enable <= wen_q;
      read_cnt <= read_cnt_next;
      write_cnt <= write_cnt_next;
      read_done <= read_done_next;
      write_done <= write_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      read_byte <= rdata;
      access_ready <= rdy;
    end
  end

endmodule

>>> hw/rtl/wait_state_sram.sv
// Byte-wide SRAM with programmable read and write wait states.
// Input channel s_*: one access item per handshake (address, write data,
// read and write enables). Output channel m_*: one result per item, the
// read data and an access-ready flag, in item order.
// Config channel cfg_*: always ready; index 0 sets read wait states,
// index 1 sets write wait states. Write only while the block is idle.
// Each item passes through accept, memory read (registered read port),
// then result calculation with the state update and any write commit.
// The next item is accepted while a result still waits in the output
// register; its calculation holds until that register is taken, so a
// stalled receiver stalls the block after at most one more item.
// Reset clears the control state, wait registers, per-direction counters
// and last-enable flags and sets the done flags; memory contents are
// undefined until written and no clearing pass runs.
module wait_state_sram
  import wss_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // address[7:0], write_byte[15:8]
  input  logic [1:0]           s_tuser,   // read_enable[0], write_enable[1]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // read_byte[7:0]
  output logic [0:0]           m_tuser,   // access_ready[0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WAIT_W-1:0]    cfg_data
);

  cmd_t   cmd;
  state_t ctrl_state;
  logic   access_ready;

  assign cfg_ready = 1'b1;

  wss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cmd        (cmd),
    .ctrl_state (ctrl_state)
  );

  wss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_address      (s_tdata[7:0]),
    .in_write_byte   (s_tdata[15:8]),
    .in_read_enable  (s_tuser[0]),
    .in_write_enable (s_tuser[1]),
    .read_byte       (m_tdata),
    .access_ready    (access_ready)
  );

  assign m_tuser[0] = access_ready;

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> ctrl_state == ST_READ && !s_tready)
    else $error("accepted item did not go to memory read");

  a_read_then_calc: assert property (@(posedge clk) disable iff (rst)
    ctrl_state == ST_READ |=> ctrl_state == ST_CALC)
    else $error("memory read not followed by calculation");

  a_result_from_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(ctrl_state == ST_CALC))
    else $error("result raised outside calculation");

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.read, cmd.calc}))
    else $error("overlapping datapath commands");

endmodule
